### hw/rtl/fpba_pkg.sv
package fpba_pkg;

   localparam int MAX_BLOCKS = 64;
   localparam int ADDR_W     = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam int SIZE_W     = 16;
   localparam int OWNER_W    = 8;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   // Function codes of an input item.
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   // Fit policy codes; the unused code behaves as first fit.
   localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'd1;

   typedef struct packed {
      logic                 func;
      logic [5:0]           entry_index;
      logic [SIZE_W-1:0]    entry_size;
      logic                 entry_free;
      logic [SIZE_W-1:0]    request_size;
      logic [OWNER_W-1:0]   owner_id;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [5:0]           block_index;
      logic [SIZE_W-1:0]    remainder_size;
      logic [OWNER_W-1:0]   granted_owner;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0]    size;
      logic                 free;
      logic [OWNER_W-1:0]   owner;
   } entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic                 rd_en;
      logic [ADDR_W-1:0]    addr;
      entry_type            wr_entry;
   } mem_req_type;

endpackage

### hw/rtl/fit_policy_block_allocator_unit.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  fpba_pkg::req_type req_data
// rsp_      out        rsp_valid/rsp_ready  fpba_pkg::rsp_type rsp_data
// csr_      in         csr_we               csr_index, csr_wdata
//
// A load transfer writes one table entry in the cycle it is accepted and its
// result goes out through the done state and the output register. An
// allocation scans the table at one entry per cycle through the single memory
// port. Reset is synchronous and clears the control state and the configuration
// registers; the table itself is undefined until loaded. A stalled result sits
// in the output register while the next item is already accepted and worked on.
module fit_policy_block_allocator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  fpba_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output fpba_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [fpba_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fpba_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic [fpba_pkg::MODE_W-1:0]     fit_mode_ff;
   logic [fpba_pkg::CSR_DATA_W-1:0] block_count_ff;

   // Output register that decouples the scan engine from the consumer.
   logic                            rsp_valid_ff, rsp_valid_in;
   fpba_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   fpba_pkg::mem_req_type           mem_req;
   fpba_pkg::entry_type             rd_entry;
   logic                            res_valid;
   logic                            res_ready;
   fpba_pkg::rsp_type               res_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff    <= fpba_pkg::FIT_FIRST;
         block_count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            fpba_pkg::CSR_FIT_MODE:    fit_mode_ff    <= csr_wdata[fpba_pkg::MODE_W-1:0];
            fpba_pkg::CSR_BLOCK_COUNT: block_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The engine hands its result over whenever the output slot is empty or
   // is being drained in the same cycle.
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   fpba_mem u_mem (
      .clock    (clock),
      .mem_req  (mem_req),
      .rd_entry (rd_entry)
   );

   fpba_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_item     (req_data),
      .fit_mode    (fit_mode_ff),
      .block_count (block_count_ff),
      .mem_req     (mem_req),
      .rd_entry    (rd_entry),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_item    (res_item)
   );

endmodule

### hw/rtl/fpba_mem.sv
module fpba_mem (
   input  logic                 clock,
   input  fpba_pkg::mem_req_type mem_req,
   output fpba_pkg::entry_type  rd_entry
);

   // Block table: one word per entry, single port, registered read.
   fpba_pkg::entry_type table_mem [fpba_pkg::MAX_BLOCKS];
   fpba_pkg::entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         table_mem[mem_req.addr] <= mem_req.wr_entry;
      end
      if (mem_req.rd_en) begin
         rd_ff <= table_mem[mem_req.addr];
      end
   end

   assign rd_entry = rd_ff;

endmodule

### hw/rtl/fpba_scan.sv
module fpba_scan (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  fpba_pkg::req_type               in_item,
   input  logic [fpba_pkg::MODE_W-1:0]     fit_mode,
   input  logic [fpba_pkg::CSR_DATA_W-1:0] block_count,
   output fpba_pkg::mem_req_type           mem_req,
   input  fpba_pkg::entry_type             rd_entry,
   output logic                            res_valid,
   input  logic                            res_ready,
   output fpba_pkg::rsp_type               res_item
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type                         state_ff, state_in;
   logic [fpba_pkg::CNT_W-1:0]        limit_ff, limit_in;
   logic [fpba_pkg::CNT_W-1:0]        iss_ff, iss_in;
   logic                              pend_ff, pend_in;
   logic [fpba_pkg::ADDR_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                              found_ff, found_in;
   logic [fpba_pkg::ADDR_W-1:0]       pick_ff, pick_in;
   logic [fpba_pkg::SIZE_W-1:0]       best_ff, best_in;
   logic [fpba_pkg::SIZE_W-1:0]       req_size_ff, req_size_in;
   logic [fpba_pkg::OWNER_W-1:0]      owner_ff, owner_in;

   logic                              issue;
   logic                              fits;
   logic                              take;
   logic [fpba_pkg::CNT_W-1:0]        count_clamped;

   // A count beyond the table depth scans the whole table.
   always_comb begin
      if (block_count > fpba_pkg::CSR_DATA_W'(fpba_pkg::MAX_BLOCKS)) begin
         count_clamped = fpba_pkg::CNT_W'(fpba_pkg::MAX_BLOCKS);
      end else begin
         count_clamped = fpba_pkg::CNT_W'(block_count);
      end
   end

   assign issue = (state_ff == S_SCAN) && (iss_ff < limit_ff);
   assign fits  = rd_entry.free && (rd_entry.size >= req_size_ff);
   // Strict compares keep the lowest index on ties.
   assign take  = fits && (!found_ff
                  || ((fit_mode == fpba_pkg::FIT_BEST)  && (rd_entry.size < best_ff))
                  || ((fit_mode == fpba_pkg::FIT_WORST) && (rd_entry.size > best_ff)));

   always_comb begin
      state_in    = state_ff;
      limit_in    = limit_ff;
      iss_in      = iss_ff;
      pend_in     = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      found_in    = found_ff;
      pick_in     = pick_ff;
      best_in     = best_ff;
      req_size_in = req_size_ff;
      owner_in    = owner_ff;
      in_ready    = 1'b0;
      res_valid   = 1'b0;

      mem_req          = '0;
      mem_req.wr_entry = '{size:  in_item.entry_size,
                           free:  in_item.entry_free,
                           owner: in_item.owner_id};

      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            mem_req.addr = in_item.entry_index;
            if (in_valid) begin
               found_in    = 1'b0;
               pick_in     = '0;
               best_in     = '0;
               req_size_in = in_item.request_size;
               owner_in    = in_item.owner_id;
               limit_in    = count_clamped;
               iss_in      = '0;
               if (in_item.func == fpba_pkg::FUNC_LOAD) begin
                  mem_req.wr_en = 1'b1;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            mem_req.rd_en = issue;
            mem_req.addr  = iss_ff[fpba_pkg::ADDR_W-1:0];
            if (issue) begin
               iss_in     = iss_ff + 1'b1;
               pend_in    = 1'b1;
               cmp_idx_in = iss_ff[fpba_pkg::ADDR_W-1:0];
            end
            if (pend_ff && take) begin
               found_in = 1'b1;
               pick_in  = cmp_idx_ff;
               best_in  = rd_entry.size;
            end
            if (!issue && !pend_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      res_item = '0;
      if (found_ff) begin
         res_item.found          = 1'b1;
         res_item.block_index    = pick_ff;
         res_item.remainder_size = best_ff - req_size_ff;
         res_item.granted_owner  = owner_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff    <= limit_in;
      iss_ff      <= iss_in;
      cmp_idx_ff  <= cmp_idx_in;
      pick_ff     <= pick_in;
      best_ff     <= best_in;
      req_size_ff <= req_size_in;
      owner_ff    <= owner_in;
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

// Block allocator testbench. A clocked driver feeds request transfers from a
// queue that the stimulus process fills, and a clocked monitor takes result
// transfers and checks them in order against a shadow allocator kept here.
// The shadow holds its own copy of the block table and of both registers and
// works out each grant at the clock edge where the request is accepted.
module tb_top;

   // Idle gaps on either side are drawn per transfer from 0 to this many cycles.
   localparam int MAX_GAP        = 6;
   // Length of the one long receiver hold-off, in cycles.
   localparam int LONG_HOLD      = 300;
   // Items per random phase.
   localparam int PHASE_ITEMS    = 48;
   // Cycles with work outstanding but no transfer on either channel before
   // the run is declared hung. The slowest correct stretch is the long hold
   // plus one full table scan, far below this.
   localparam int WATCHDOG_LIMIT = 2000;
   // The unused fit code, which the block must treat as first fit.
   localparam logic [fpba_pkg::MODE_W-1:0] FIT_SPARE = 2'd3;

   typedef enum {STRESS_NONE, STRESS_RX_HOLD, STRESS_TX_PAUSE} stress_type;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   fpba_pkg::req_type               req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   fpba_pkg::rsp_type               rsp_data;
   logic                            csr_we    = 1'b0;
   logic [fpba_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [fpba_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Requests waiting to be offered, and grants waiting to come back.
   fpba_pkg::req_type request_queue[$];
   fpba_pkg::rsp_type grant_queue[$];

   // Shadow of the block table and of the two registers, as seen at the
   // moment a request transfer happens.
   logic [fpba_pkg::SIZE_W-1:0]  table_size  [fpba_pkg::MAX_BLOCKS];
   logic                         table_free  [fpba_pkg::MAX_BLOCKS];
   logic [fpba_pkg::OWNER_W-1:0] table_owner [fpba_pkg::MAX_BLOCKS];
   logic [fpba_pkg::MODE_W-1:0]  cur_mode  = fpba_pkg::FIT_FIRST;
   logic [6:0]                   cur_count = '0;

   // Sizes as they will be once every queued load has gone through. This is
   // only used to aim request sizes at sizes that really sit in the table.
   logic [fpba_pkg::SIZE_W-1:0]  planned_size [fpba_pkg::MAX_BLOCKS];

   // Knobs that the stimulus process sets between phases, always at a falling
   // edge so that the clocked processes never race with the change.
   bit idle_enable  = 1'b0;
   bit narrow_sizes = 1'b0;
   int stall_token  = 0;

   int mismatch_count = 0;
   int quiet_cycles   = 0;

   fit_policy_block_allocator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int draw_wait();
      return idle_enable ? $urandom_range(0, MAX_GAP) : 0;
   endfunction

   // Shadow allocator. A load writes one entry and answers with an all-zero
   // result. An allocation scans the first block_count entries (capped at the
   // table depth) for a free block at least as large as the request. First
   // fit stops at the first hit, best fit keeps the smallest, worst fit the
   // largest; strict comparisons keep the lowest index on a tie. The unused
   // mode code falls through to first fit.
   function automatic fpba_pkg::rsp_type predict_grant(fpba_pkg::req_type item);
      fpba_pkg::rsp_type grant;
      int                limit;
      int                i;
      bit                hit;
      int                pick;
      grant = '0;
      if (item.func == fpba_pkg::FUNC_LOAD) begin
         table_size[item.entry_index]  = item.entry_size;
         table_free[item.entry_index]  = item.entry_free;
         table_owner[item.entry_index] = item.owner_id;
         return grant;
      end
      limit = (cur_count > fpba_pkg::MAX_BLOCKS) ? fpba_pkg::MAX_BLOCKS : cur_count;
      hit   = 1'b0;
      pick  = 0;
      for (i = 0; i < limit; i++) begin
         if (table_free[i] && table_size[i] >= item.request_size) begin
            if (!hit) begin
               hit  = 1'b1;
               pick = i;
               if (cur_mode != fpba_pkg::FIT_BEST && cur_mode != fpba_pkg::FIT_WORST) begin
                  break;
               end
            end else if (cur_mode == fpba_pkg::FIT_BEST
                         && table_size[i] < table_size[pick]) begin
               pick = i;
            end else if (cur_mode == fpba_pkg::FIT_WORST
                         && table_size[i] > table_size[pick]) begin
               pick = i;
            end
         end
      end
      if (hit) begin
         grant.found          = 1'b1;
         grant.block_index    = pick[5:0];
         grant.remainder_size = table_size[pick] - item.request_size;
         grant.granted_owner  = item.owner_id;
      end
      return grant;
   endfunction

   // Driver. The request held on the bus stays untouched until its transfer;
   // after each transfer the next one waits out a freshly drawn gap. Each
   // signal gets at most one nonblocking update per edge.
   int send_wait = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            grant_queue.push_back(predict_grant(req_data));
         end
         if (req_valid && !req_ready) begin
            // Still waiting for the block to take the current request.
         end else if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (request_queue.size() != 0) begin
            req_data  <= request_queue.pop_front();
            req_valid <= 1'b1;
            send_wait = draw_wait();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor. Every result transfer is checked field by field against the
   // oldest grant still waiting. Ready drops for a drawn number of cycles
   // after each transfer, and once for a long hold-off on request from the
   // stimulus process, counted down here.
   int ready_wait = 0;
   int hold_left  = 0;
   int stall_seen = 0;
   always @(posedge clock) begin
      fpba_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (grant_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result with nothing outstanding: found=%0d index=%0d",
                           $time, rsp_data.found, rsp_data.block_index);
               end
            end else begin
               want = grant_queue.pop_front();
               if (rsp_data.found !== want.found
                   || rsp_data.block_index !== want.block_index
                   || rsp_data.remainder_size !== want.remainder_size
                   || rsp_data.granted_owner !== want.granted_owner) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     // Fields in order: found, index, remainder, owner.
                     $display("%0t: mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              $time, want.found, want.block_index, want.remainder_size,
                              want.granted_owner, rsp_data.found, rsp_data.block_index,
                              rsp_data.remainder_size, rsp_data.granted_owner);
                  end
               end
            end
            ready_wait = draw_wait();
         end
         if (stall_token != stall_seen) begin
            stall_seen = stall_token;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (ready_wait > 0) begin
            ready_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog. Only cycles with work outstanding and no transfer on either
   // channel count toward the limit.
   always @(posedge clock) begin
      if (!reset) begin
         if ((request_queue.size() != 0 || req_valid || grant_queue.size() != 0)
             && !(req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
            quiet_cycles++;
         end else begin
            quiet_cycles = 0;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Waits until every queued request has gone through and every grant has
   // come back. Every item answers with exactly one result, so once the last
   // one is in the block is idle; a few spare cycles are added anyway.
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (request_queue.size() != 0 || req_valid || grant_queue.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [fpba_pkg::CSR_IDX_W-1:0] index,
                            input logic [fpba_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == fpba_pkg::CSR_FIT_MODE) begin
         cur_mode = value[fpba_pkg::MODE_W-1:0];
      end else begin
         cur_count = value;
      end
   endtask

   // Registers only change once the block has gone quiet.
   task automatic set_config(input logic [fpba_pkg::MODE_W-1:0] mode,
                             input int unsigned count);
      wait_idle();
      write_reg(fpba_pkg::CSR_FIT_MODE, fpba_pkg::CSR_DATA_W'(mode));
      write_reg(fpba_pkg::CSR_BLOCK_COUNT, fpba_pkg::CSR_DATA_W'(count));
   endtask

   // A load carries random junk in the request size, so that field toggles
   // on items where the block must ignore it.
   task automatic queue_load(input logic [5:0] index,
                             input logic [fpba_pkg::SIZE_W-1:0] size,
                             input logic free,
                             input logic [fpba_pkg::OWNER_W-1:0] owner);
      fpba_pkg::req_type item;
      item              = '0;
      item.func         = fpba_pkg::FUNC_LOAD;
      item.entry_index  = index;
      item.entry_size   = size;
      item.entry_free   = free;
      item.request_size = fpba_pkg::SIZE_W'($urandom);
      item.owner_id     = owner;
      planned_size[index] = size;
      request_queue.push_back(item);
   endtask

   // Likewise an allocation carries junk in the entry fields.
   task automatic queue_alloc(input logic [fpba_pkg::SIZE_W-1:0] size,
                              input logic [fpba_pkg::OWNER_W-1:0] owner);
      fpba_pkg::req_type item;
      item              = '0;
      item.func         = fpba_pkg::FUNC_ALLOC;
      item.entry_index  = 6'($urandom);
      item.entry_size   = fpba_pkg::SIZE_W'($urandom);
      item.entry_free   = 1'($urandom);
      item.request_size = size;
      item.owner_id     = owner;
      request_queue.push_back(item);
   endtask

   // Narrow phases draw from a few coarse sizes so that ties are common.
   function automatic logic [fpba_pkg::SIZE_W-1:0] pick_entry_size();
      if (narrow_sizes) begin
         return fpba_pkg::SIZE_W'($urandom_range(0, 12) * 8);
      end
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return fpba_pkg::SIZE_W'($urandom_range(0, 200));
         default: return fpba_pkg::SIZE_W'($urandom);
      endcase
   endfunction

   // Requests mostly sit right on or next to a size that is in the table, so
   // that the size test is exercised at its boundary and hits and misses mix.
   function automatic logic [fpba_pkg::SIZE_W-1:0] pick_request();
      logic [fpba_pkg::SIZE_W-1:0] base;
      base = planned_size[$urandom_range(0, fpba_pkg::MAX_BLOCKS - 1)];
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return base;
         5:       return base + 1'b1;
         6:       return base - 1'b1;
         7:       return fpba_pkg::SIZE_W'($urandom_range(0, 255));
         default: return fpba_pkg::SIZE_W'($urandom);
      endcase
   endfunction

   // One random phase: set the registers, then queue a batch of mixed loads
   // and allocations. A phase may also ask for the long receiver hold-off, or
   // have the sender stop halfway until every grant is back.
   task automatic run_phase(input logic [fpba_pkg::MODE_W-1:0] mode,
                            input int unsigned count, input bit idle_on,
                            input bit narrow, input stress_type stress);
      int n;
      set_config(mode, count);
      @(negedge clock);
      idle_enable  = idle_on;
      narrow_sizes = narrow;
      if (stress == STRESS_RX_HOLD) begin
         stall_token++;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
         if (stress == STRESS_TX_PAUSE && n == PHASE_ITEMS / 2) begin
            wait_idle();
         end
         if ($urandom_range(0, 3) == 0) begin
            queue_load(6'($urandom_range(0, fpba_pkg::MAX_BLOCKS - 1)), pick_entry_size(),
                       logic'($urandom_range(0, 3) != 0), fpba_pkg::OWNER_W'($urandom));
         end else begin
            queue_alloc(pick_request(), fpba_pkg::OWNER_W'($urandom));
         end
      end
   endtask

   initial begin
      int order [fpba_pkg::MAX_BLOCKS];
      int i;
      int j;
      int swap;

      for (i = 0; i < fpba_pkg::MAX_BLOCKS; i++) begin
         planned_size[i] = '0;
         order[i] = i;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_enable = 1'b1;

      // Directed part. Right after reset the block count is zero, so an
      // allocation scans nothing and must come back empty.
      queue_alloc(16'd5, 8'h11);

      // A small table with the interesting shapes: a free block of size zero,
      // two largest blocks that tie, a busy block, two equal mid-size blocks.
      queue_load(6'd0, 16'd0,     1'b1, 8'h00);
      queue_load(6'd1, 16'hFFFF,  1'b1, 8'hFF);
      queue_load(6'd2, 16'd100,   1'b0, 8'h22);
      queue_load(6'd3, 16'd40,    1'b1, 8'h33);
      queue_load(6'd4, 16'd40,    1'b1, 8'h44);
      queue_load(6'd5, 16'd300,   1'b1, 8'h55);
      queue_load(6'd6, 16'hFFFF,  1'b1, 8'h66);
      queue_load(6'd7, 16'd10,    1'b1, 8'h77);

      // First fit: a zero request takes the empty block, a full-size request
      // only fits the largest, and a mid request stops at the first fit.
      set_config(fpba_pkg::FIT_FIRST, 8);
      queue_alloc(16'd0,    8'h01);
      queue_alloc(16'hFFFF, 8'hFF);
      queue_alloc(16'd50,   8'h80);

      // Best fit with ties on the smallest and on the largest fitting size.
      set_config(fpba_pkg::FIT_BEST, 8);
      queue_alloc(16'd30,   8'h5A);
      queue_alloc(16'hFFFF, 8'hA5);
      queue_alloc(16'd301,  8'h3C);

      // Worst fit, including a zero request.
      set_config(fpba_pkg::FIT_WORST, 8);
      queue_alloc(16'd30, 8'hC3);
      queue_alloc(16'd0,  8'h0F);

      // The unused mode code behaves as first fit.
      set_config(FIT_SPARE, 8);
      queue_alloc(16'd30, 8'hF0);

      // A one-entry scan: the empty block fits only a zero request.
      set_config(fpba_pkg::FIT_FIRST, 1);
      queue_alloc(16'd1, 8'h12);
      queue_alloc(16'd0, 8'h34);
      wait_idle();

      // Fill every entry in shuffled order so that any block count can be
      // scanned without touching an entry that was never written.
      for (i = fpba_pkg::MAX_BLOCKS - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         swap     = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      for (i = 0; i < fpba_pkg::MAX_BLOCKS; i++) begin
         queue_load(6'(order[i]), pick_entry_size(), logic'($urandom_range(0, 3) != 0),
                    fpba_pkg::OWNER_W'($urandom));
      end

      // Random phases over every mode and a spread of block counts, from
      // zero to the register's largest value, which must clamp to the table.
      run_phase(fpba_pkg::FIT_FIRST, 64,  1'b1, 1'b0, STRESS_NONE);
      run_phase(fpba_pkg::FIT_BEST,  127, 1'b1, 1'b1, STRESS_NONE);
      run_phase(fpba_pkg::FIT_WORST, 65,  1'b0, 1'b1, STRESS_NONE);
      run_phase(fpba_pkg::FIT_BEST,  64,  1'b1, 1'b0, STRESS_RX_HOLD);
      run_phase(FIT_SPARE,           1,   1'b1, 1'b0, STRESS_NONE);
      run_phase(fpba_pkg::FIT_WORST, 64,  1'b1, 1'b1, STRESS_TX_PAUSE);
      run_phase(fpba_pkg::FIT_FIRST, 0,   1'b0, 1'b0, STRESS_NONE);
      run_phase(fpba_pkg::FIT_BEST,  40,  1'b1, 1'b1, STRESS_NONE);
      run_phase(fpba_pkg::FIT_WORST, 127, 1'b1, 1'b0, STRESS_NONE);
      run_phase(fpba_pkg::FIT_FIRST, 2,   1'b0, 1'b1, STRESS_NONE);
      run_phase(fpba_pkg::FIT_BEST,  64,  1'b1, 1'b0, STRESS_NONE);

      // Let everything drain, then give the block time to show any stray
      // result before the verdict.
      wait_idle();
      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && grant_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
